[hdl/grayscale_histogram_engine_macros.svh]
// ---------------------------------------------------------------------------
// Histogram engine assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef GRAYSCALE_HISTOGRAM_ENGINE_MACROS_SVH
`define GRAYSCALE_HISTOGRAM_ENGINE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define GHE_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GHE_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GHE_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg)
`define GHE_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg)
`endif

`endif

[hdl/ghe_pkg.sv]
// ---------------------------------------------------------------------------
// Histogram engine package
// Shared constants, operation codes and control types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ghe_pkg;

  localparam int LEVELS_DEF     = 256;
  localparam int COUNT_BITS_DEF = 32;

  localparam int KIND_W       = 2;
  localparam int PIX_W        = 8;
  localparam int OUT_W        = 32;
  localparam int NUM_LEVELS_W = 9;

  localparam logic [NUM_LEVELS_W-1:0] NUM_LEVELS_RST = 9'd256;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // clear sequencer status toward the datapath
  typedef struct packed {
    logic busy;
    logic wr_en;
  } clr_ctrl_t;

endpackage

`default_nettype wire

[hdl/ghe_mem.sv]
// ---------------------------------------------------------------------------
// Histogram bin store
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ghe_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/ghe_clear.sv]
// ---------------------------------------------------------------------------
// Histogram clear sequencer
// Sweeps bins 0..last writing zero, one bin per cycle; runs over all bins
// after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ghe_clear #(
  parameter int LEVELS = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [$clog2(LEVELS)-1:0] last_addr,
  output ghe_pkg::clr_ctrl_t             ctrl,
  output logic      [$clog2(LEVELS)-1:0] addr
);

  import ghe_pkg::*;

  localparam int ADDR_W = $clog2(LEVELS);

  logic              busy_r, busy_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;

  always_comb begin
    busy_nxt = busy_r;
    addr_nxt = addr_r;
    end_nxt  = end_r;
    if (busy_r) begin
      if (addr_r == end_r) begin
        busy_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      addr_nxt = '0;
      end_nxt  = last_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
      end_r  <= ADDR_W'(LEVELS - 1);
    end else begin
      busy_r <= busy_nxt;
      addr_r <= addr_nxt;
      end_r  <= end_nxt;
    end
  end

  assign ctrl.busy  = busy_r;
  assign ctrl.wr_en = busy_r;
  assign addr       = addr_r;

endmodule

`default_nettype wire

[hdl/grayscale_histogram_engine.sv]
// A read item reads the RAM in stage 1; its result is then held in the output register.
// Throughput: one pixel or read item per cycle unless a clear pass runs or a held
//   read result stalls; same-bin pixels back to back are forwarded around the registered RAM read.
// A clear item blocks input while the clear sequencer zeroes every bin in use.
// Reset: synchronous; a clearing pass over all LEVELS bins follows, input held off.
// Configuration writes are taken in any cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "grayscale_histogram_engine_macros.svh"

// ---------------------------------------------------------------------------
// Grayscale histogram engine
// Saturating per-level pixel counters in one RAM, read-modify-write pipeline.
// ---------------------------------------------------------------------------
module grayscale_histogram_engine #(
  parameter int LEVELS     = ghe_pkg::LEVELS_DEF,
  parameter int COUNT_BITS = ghe_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: pixel_value [7:0], bin_index [15:8]
  input  wire logic [15:0]                      in_tdata,
  // in_tuser: kind [1:0]
  input  wire logic [ghe_pkg::KIND_W-1:0]       in_tuser,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // out_tdata: bin_count [31:0]
  output logic      [ghe_pkg::OUT_W-1:0]        out_tdata,
  // out_tuser: bin_valid [0]
  output logic      [0:0]                       out_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [ghe_pkg::NUM_LEVELS_W-1:0] cfg_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready
);

  import ghe_pkg::*;

  localparam int ADDR_W = $clog2(LEVELS);
  localparam int LV_W   = $clog2(LEVELS + 1);
  localparam int CMP_W  = (LV_W > NUM_LEVELS_W) ? LV_W : NUM_LEVELS_W;

  logic [NUM_LEVELS_W-1:0] num_levels_r;

  logic [PIX_W-1:0] pixel_value;
  logic [PIX_W-1:0] bin_index;
  logic             accept;
  logic             stall;
  logic             advance;

  logic [CMP_W-1:0] nl_ext, lv_ext;
  logic             pix_ok, idx_ok, clr_start;

  clr_ctrl_t         clr_ctrl;
  logic [ADDR_W-1:0] clr_addr;

  logic              s1_pix_r, s1_rd_r, s1_ok_r;
  logic [ADDR_W-1:0] s1_addr_r;

  logic                  fwd_en_r;
  logic [ADDR_W-1:0]     fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic                  mem_wr_en, mem_rd_en, pix_wr;
  logic [ADDR_W-1:0]     mem_wr_addr, mem_rd_addr;
  logic [COUNT_BITS-1:0] mem_wr_data, mem_rd_data, cur_count;
  logic [OUT_W-1:0]      sat_count;

  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_count_r;
  logic             out_valid_flag_r;

  assign pixel_value = in_tdata[7:0];
  assign bin_index   = in_tdata[15:8];

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r <= NUM_LEVELS_RST;
    end else if (cfg_valid && cfg_ready) begin
      num_levels_r <= cfg_data;
    end
  end

  // bins in use: num_levels capped at LEVELS
  assign nl_ext = CMP_W'(num_levels_r);
  assign lv_ext = (nl_ext > CMP_W'(LEVELS)) ? CMP_W'(LEVELS) : nl_ext;
  assign pix_ok = CMP_W'(pixel_value) < lv_ext;
  assign idx_ok = CMP_W'(bin_index) < lv_ext;

  // a held read result blocks the read waiting behind it
  assign stall     = s1_rd_r && out_tvalid_r && !out_tready;
  assign advance   = !stall;
  assign in_tready = !clr_ctrl.busy && advance;
  assign accept    = in_tvalid && in_tready;
  assign clr_start = accept && (in_tuser == KIND_CLEAR) && (lv_ext != '0);

  ghe_clear #(
    .LEVELS(LEVELS)
  ) u_clear (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (clr_start),
    .last_addr(ADDR_W'(lv_ext - CMP_W'(1))),
    .ctrl     (clr_ctrl),
    .addr     (clr_addr)
  );

  // stage 1: item waits for its RAM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pix_r <= 1'b0;
      s1_rd_r  <= 1'b0;
    end else if (accept) begin
      s1_pix_r <= (in_tuser == KIND_PIXEL);
      s1_rd_r  <= (in_tuser == KIND_READ);
    end else if (advance) begin
      s1_pix_r <= 1'b0;
      s1_rd_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok_r   <= (in_tuser == KIND_PIXEL) ? pix_ok : idx_ok;
      s1_addr_r <= mem_rd_addr;
    end
  end

  assign mem_rd_en   = accept;
  assign mem_rd_addr = (in_tuser == KIND_PIXEL) ? ADDR_W'(pixel_value) : ADDR_W'(bin_index);

  // forward the write made at the same edge as this item's read
  assign cur_count = (fwd_en_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : mem_rd_data;

  assign pix_wr      = s1_pix_r && s1_ok_r && (cur_count != '1);
  assign mem_wr_en   = clr_ctrl.wr_en || pix_wr;
  assign mem_wr_addr = clr_ctrl.wr_en ? clr_addr : s1_addr_r;
  assign mem_wr_data = clr_ctrl.wr_en ? '0 : cur_count + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r <= 1'b0;
    end else if (advance) begin
      fwd_en_r <= mem_wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_addr_r <= mem_wr_addr;
      fwd_data_r <= mem_wr_data;
    end
  end

  ghe_mem #(
    .DEPTH(LEVELS),
    .WIDTH(COUNT_BITS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  // result count limited to the output width
  generate
    if (COUNT_BITS > OUT_W) begin : g_sat
      assign sat_count = (|cur_count[COUNT_BITS-1:OUT_W]) ? '1 : cur_count[OUT_W-1:0];
    end else begin : g_ext
      assign sat_count = OUT_W'(cur_count);
    end
  endgenerate

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s1_rd_r && advance) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rd_r && advance) begin
      out_count_r      <= s1_ok_r ? sat_count : '0;
      out_valid_flag_r <= s1_ok_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_count_r;
  assign out_tuser[0] = out_valid_flag_r;

  `GHE_ASSERT_IMP(a_clr_blocks_in, clk, rst_n, clr_ctrl.busy, !in_tready, "item taken during clear pass")
  `GHE_ASSERT_IMP(a_no_pix_in_clr, clk, rst_n, clr_ctrl.wr_en, !(s1_pix_r || s1_rd_r), "pipeline busy during clear pass")
  `GHE_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == '0, "invalid bin with nonzero count")
  `GHE_ASSERT_NEXT(a_read_result, clk, rst_n, s1_rd_r && advance, out_tvalid, "read item gave no result")

endmodule

`default_nettype wire
